// ===== hdl/scfd_pkg.sv =====
// Shared types and constants for the serial CAN frame deframer.
package scfd_pkg;

  localparam logic [7:0] SYNC_FIRST     = 8'hAB;
  localparam logic [7:0] SYNC_SECOND    = 8'hCD;
  localparam int         MAX_DATA_BYTES = 8;
  localparam int         HEADER_BYTES   = 6;
  localparam int         ID_BYTES       = 4;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_FLAGS = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_LEN = 1'b1;

  typedef struct packed {
    logic        status;
    logic [31:0] identifier;
    logic        is_remote;
    logic        is_extended;
    logic        is_self;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [3:0]  frame_bytes;
  } result_t;

endpackage

// ===== hdl/serial_can_frame_deframer.sv =====
// Serial CAN frame deframer: sync hunt, header collection and frame assembly.
// A byte is registered at the input, then decoded; its result word, if any, is loaded
//   into the output register when the byte is decoded.
// Throughput: one byte per cycle while the output is not stalled; the single decode step per byte sets this rate.
// Reset (synchronous, rst_n low): empty input and output registers, hunt for the
//   first sync byte, all frame state cleared.
module serial_can_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [31:0] out_identifier,
  output logic        out_is_remote,
  output logic        out_is_extended,
  output logic        out_is_self,
  output logic [3:0]  out_data_length,
  output logic [63:0] out_payload,
  output logic [3:0]  out_frame_bytes
);

  // Input register: one received byte waiting for decode.
  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  // Frame state.
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] id_r, id_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [63:0] pay_r, pay_nxt;

  // Output register.
  logic                   out_vld_r, out_vld_nxt;
  scfd_pkg::result_t      res_r, res_nxt;

  logic        adv;     // decode the held byte this cycle
  logic        emit;    // the held byte closes a frame or reports an error
  logic [63:0] pay_upd;
  logic [3:0]  idx_inc;
  logic [7:0]  b;

  // Decode whenever the output register is free or is being drained.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign b        = in_byte_r;
  assign idx_inc  = idx_r + 4'd1;

  // Drop the byte into its lane of the payload.
  always_comb begin
    pay_upd = pay_r;
    for (int k = 0; k < 8; k++) begin
      if (idx_r[2:0] == 3'(k)) begin
        pay_upd[8*k +: 8] = b;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    id_nxt    = id_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    pay_nxt   = pay_r;
    emit      = 1'b0;
    res_nxt.status      = scfd_pkg::ST_OK;
    res_nxt.identifier  = id_r;
    res_nxt.is_remote   = flags_r[0];
    res_nxt.is_extended = flags_r[1];
    res_nxt.is_self     = flags_r[2];
    res_nxt.data_length = len_r;
    res_nxt.payload     = pay_upd;
    res_nxt.frame_bytes = 4'(scfd_pkg::HEADER_BYTES) + len_r;

    unique case (phase_r)
      scfd_pkg::PH_HUNT: begin
        if (b == scfd_pkg::SYNC_FIRST) begin
          phase_nxt = scfd_pkg::PH_SYNC2;
        end
      end
      scfd_pkg::PH_SYNC2: begin
        // A repeated first sync byte stays a candidate.
        if (b == scfd_pkg::SYNC_SECOND) begin
          phase_nxt = scfd_pkg::PH_ID;
          idx_nxt   = '0;
          id_nxt    = '0;
        end else if (b != scfd_pkg::SYNC_FIRST) begin
          phase_nxt = scfd_pkg::PH_HUNT;
        end
      end
      scfd_pkg::PH_ID: begin
        id_nxt = {id_r[23:0], b};
        if (idx_inc >= 4'(scfd_pkg::ID_BYTES)) begin
          idx_nxt   = '0;
          phase_nxt = scfd_pkg::PH_FLAGS;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      scfd_pkg::PH_FLAGS: begin
        flags_nxt = b[2:0];
        phase_nxt = scfd_pkg::PH_LEN;
      end
      scfd_pkg::PH_LEN: begin
        if (b > 8'(scfd_pkg::MAX_DATA_BYTES)) begin
          emit                = 1'b1;
          res_nxt.status      = scfd_pkg::ST_BAD_LEN;
          res_nxt.data_length = b[3:0];
          res_nxt.payload     = '0;
          res_nxt.frame_bytes = '0;
        end else if (b == 8'd0) begin
          emit                = 1'b1;
          res_nxt.data_length = '0;
          res_nxt.payload     = '0;
          res_nxt.frame_bytes = 4'(scfd_pkg::HEADER_BYTES);
        end else begin
          len_nxt   = b[3:0];
          pay_nxt   = '0;
          idx_nxt   = '0;
          phase_nxt = scfd_pkg::PH_DATA;
        end
      end
      scfd_pkg::PH_DATA: begin
        pay_nxt = pay_upd;
        idx_nxt = idx_inc;
        if (idx_inc >= len_r) begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_nxt = scfd_pkg::PH_HUNT;
      end
    endcase

    // Close the frame, or leave an illegal phase: back to hunting with clean state.
    if (emit || phase_r > scfd_pkg::PH_DATA) begin
      phase_nxt = scfd_pkg::PH_HUNT;
      idx_nxt   = '0;
      id_nxt    = '0;
      flags_nxt = '0;
      len_nxt   = '0;
      pay_nxt   = '0;
    end
  end

  // Load a new word on decode, drop the old one once taken.
  always_comb begin
    if (adv) begin
      out_vld_nxt = emit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= scfd_pkg::PH_HUNT;
      idx_r     <= '0;
      id_r      <= '0;
      flags_r   <= '0;
      len_r     <= '0;
      pay_r     <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        id_r    <= id_nxt;
        flags_r <= flags_nxt;
        len_r   <= len_nxt;
        pay_r   <= pay_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = res_r.status;
  assign out_identifier  = res_r.identifier;
  assign out_is_remote   = res_r.is_remote;
  assign out_is_extended = res_r.is_extended;
  assign out_is_self     = res_r.is_self;
  assign out_data_length = res_r.data_length;
  assign out_payload     = res_r.payload;
  assign out_frame_bytes = res_r.frame_bytes;

`ifndef NO_ASSERTIONS
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit |=> out_vld_r)
    else $error("decoded frame did not reach the output register");

  a_bad_len_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status == scfd_pkg::ST_BAD_LEN |->
      out_frame_bytes == 4'd0 && out_payload == 64'd0)
    else $error("error word carries frame data");

  a_ok_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status == scfd_pkg::ST_OK |->
      out_frame_bytes == 4'(scfd_pkg::HEADER_BYTES) + out_data_length &&
      out_data_length <= 4'(scfd_pkg::MAX_DATA_BYTES))
    else $error("frame word length fields disagree");

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == scfd_pkg::PH_DATA |-> idx_r < len_r)
    else $error("data byte index ran past the frame length");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(res_r))
    else $error("stalled output word changed");
`endif

endmodule
